[src/deadline_ordered_job_timer_defines.svh]
// Assertion macros shared by the deadline job timer checkers.
`ifndef DEADLINE_ORDERED_JOB_TIMER_DEFINES_SVH
`define DEADLINE_ORDERED_JOB_TIMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define DOJT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dojt port check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define DOJT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dojt port check failed");

`endif

[src/dojt_pkg.sv]
// Types, codes and widths shared by the deadline job timer modules.
package dojt_pkg;

  localparam int TimeW   = 48;
  localparam int DelayW  = 32;
  localparam int IdW     = 16;
  localparam int CmdW    = 2;
  localparam int StatusW = 3;
  localparam int SDataW  = TimeW + DelayW + 2 * IdW;
  localparam int MDataW  = 2 * IdW + TimeW;
  localparam int MaxOut  = 64;
  localparam int NW      = $clog2(MaxOut + 1);

  localparam logic [CmdW-1:0] CMD_RESERVE    = 2'd0;
  localparam logic [CmdW-1:0] CMD_DISTRIBUTE = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR      = 2'd2;

  localparam logic [StatusW-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd1;
  localparam logic [StatusW-1:0] ST_DUE      = 3'd2;
  localparam logic [StatusW-1:0] ST_NONE     = 3'd3;
  localparam logic [StatusW-1:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [IdW-1:0]   owner;
    logic [IdW-1:0]   job;
    logic [TimeW-1:0] due;
  } entry_t;

  typedef enum logic {
    ALU_ADD,
    ALU_CMP
  } alu_op_t;

  typedef struct packed {
    logic             gt;
    logic [TimeW-1:0] sum;
  } alu_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_DIS_RD,
    S_DIS_CMP,
    S_DIS_END,
    S_DONE
  } state_t;

endpackage

[src/deadline_ordered_job_timer.sv]
// Top level of the deadline-ordered job timer queue.
// Reserve: add the delay, move each later entry up one slot, then write the new one.
// Clear, or a reserve into a full queue, goes straight to its result. Distribute
// releases due head entries until one is not due, the queue is empty or 64 are out;
// due entries stream out as found. One item at a time, ready only when idle; result-side stalls hold it busy.
// Reset (rst, synchronous) empties the queue and drops any pending result; memory not cleared.
module deadline_ordered_job_timer import dojt_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // s_tdata: now_time[47:0], delay_ticks[79:48], owner_id[95:80], job_handle[111:96]
  input  logic [SDataW-1:0]  s_tdata,
  // s_tuser: cmd[1:0]
  input  logic [CmdW-1:0]    s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // m_tdata: out_owner[15:0], out_job[31:16], due_time[79:32]
  output logic [MDataW-1:0]  m_tdata,
  // m_tuser: status[2:0]
  output logic [StatusW-1:0] m_tuser,
  output logic               m_tlast
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Add two slot indexes modulo the capacity; both are below it.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] x, input logic [AW-1:0] y);
    logic [AW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  // Control state
  state_t        state;
  state_t        state_next;
  logic [AW-1:0] head;        // slot of the earliest entry (circular buffer)
  logic [CW-1:0] count;       // number of valid entries
  logic [CW-1:0] pos;         // insertion point, relative to head
  logic [NW-1:0] n;           // entries released by the current distribute
  logic          held_valid;  // a due entry waits for its last flag
  logic          out_valid;

  // Payload
  logic [TimeW-1:0]   now_q;
  logic [DelayW-1:0]  delay_q;
  logic [IdW-1:0]     owner_q;
  logic [IdW-1:0]     job_q;
  logic [TimeW-1:0]   due_new;
  entry_t             held;
  entry_t             res_entry;
  logic [StatusW-1:0] res_status;
  entry_t             out_entry;
  logic [StatusW-1:0] out_status;
  logic               out_last;

  // Memory and shared unit hookup
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        rd_entry;

  alu_op_t          alu_op;
  logic [TimeW-1:0] alu_a;
  logic [TimeW-1:0] alu_b;
  alu_res_t         alu_res;

  logic accept;
  logic can_emit;
  logic full;
  logic more;
  logic load_out;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign can_emit = !out_valid || m_tready;
  assign full     = (count == CW'(CAPACITY));
  assign more     = (count != '0) && (n < NW'(MaxOut));
  // Load the output register: a non-last released job, or the closing beat
  assign load_out = ((state == S_DIS_CMP) && !alu_res.gt && held_valid && can_emit) ||
                    ((state == S_DONE) && can_emit);

  dojt_store #(.Depth(CAPACITY)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_entry)
  );

  dojt_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (s_tuser)
            CMD_RESERVE:    state_next = full ? S_DONE : S_ADD;
            CMD_DISTRIBUTE: state_next = S_DIS_RD;
            CMD_CLEAR:      state_next = S_DONE;
            default:        state_next = S_IDLE;  // unused command: drop
          endcase
        end
      end
      S_ADD:     state_next = S_INS_RD;
      S_INS_RD:  state_next = (pos == '0) ? S_INS_WR : S_INS_CMP;
      S_INS_CMP: state_next = alu_res.gt ? S_INS_RD : S_INS_WR;
      S_INS_WR:  state_next = S_DONE;
      S_DIS_RD:  state_next = more ? S_DIS_CMP : S_DIS_END;
      S_DIS_CMP: begin
        if (alu_res.gt) begin
          state_next = S_DIS_END;
        end else if (!held_valid || can_emit) begin
          state_next = S_DIS_RD;
        end
      end
      S_DIS_END: state_next = S_DONE;
      S_DONE:    state_next = can_emit ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory port and shared unit selection
  always_comb begin
    alu_op    = ALU_CMP;
    alu_a     = rd_entry.due;
    alu_b     = due_new;
    mem_re    = 1'b0;
    mem_raddr = head;
    mem_we    = 1'b0;
    mem_waddr = wrap_add(head, pos[AW-1:0]);
    mem_wdata = rd_entry;
    unique case (state)
      S_ADD: begin
        // due = now + delay, saturated at the largest time
        alu_op = ALU_ADD;
        alu_a  = now_q;
        alu_b  = {{(TimeW-DelayW){1'b0}}, delay_q};
      end
      S_INS_RD: begin
        // Fetch the entry just below the insertion point
        if (pos != '0) begin
          mem_re    = 1'b1;
          mem_raddr = wrap_add(head, pos[AW-1:0] - AW'(1));
        end
      end
      S_INS_CMP: begin
        // Later entry moves up one slot; equal times stay ahead of the new one
        mem_we = alu_res.gt;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_wdata = '{owner: owner_q, job: job_q, due: due_new};
      end
      S_DIS_RD: begin
        mem_re = more;
      end
      S_DIS_CMP: begin
        alu_b = now_q;
      end
      default: begin
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      n          <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            now_q      <= s_tdata[TimeW-1:0];
            delay_q    <= s_tdata[TimeW+DelayW-1:TimeW];
            owner_q    <= s_tdata[TimeW+DelayW+IdW-1:TimeW+DelayW];
            job_q      <= s_tdata[SDataW-1:TimeW+DelayW+IdW];
            n          <= '0;
            held_valid <= 1'b0;
            res_entry  <= '0;
            case (s_tuser)
              CMD_RESERVE: begin
                res_status <= ST_FULL;
              end
              CMD_CLEAR: begin
                count      <= '0;
                head       <= '0;
                res_status <= ST_CLEARED;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD: begin
          due_new <= alu_res.sum;
          pos     <= count;
        end
        S_INS_CMP: begin
          if (alu_res.gt) begin
            pos <= pos - CW'(1);
          end
        end
        S_INS_WR: begin
          count      <= count + CW'(1);
          res_status <= ST_ACCEPTED;
          res_entry  <= '{owner: owner_q, job: job_q, due: due_new};
        end
        S_DIS_CMP: begin
          // Pop a due head entry; release the one before it, which is not last
          if (!alu_res.gt && (!held_valid || can_emit)) begin
            held       <= rd_entry;
            held_valid <= 1'b1;
            head       <= wrap_add(head, AW'(1));
            count      <= count - CW'(1);
            n          <= n + NW'(1);
            if (held_valid) begin
              out_entry  <= held;
              out_status <= ST_DUE;
              out_last   <= 1'b0;
            end
          end
        end
        S_DIS_END: begin
          held_valid <= 1'b0;
          if (held_valid) begin
            res_status <= ST_DUE;
            res_entry  <= held;
          end else begin
            res_status <= ST_NONE;
            res_entry  <= '0;
          end
        end
        S_DONE: begin
          if (can_emit) begin
            out_entry  <= res_entry;
            out_status <= res_status;
            out_last   <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_entry.due, out_entry.job, out_entry.owner};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

endmodule

[src/dojt_store.sv]
// Entry memory: one write port, one read port with registered read data.
module dojt_store import dojt_pkg::*; #(
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/dojt_alu.sv]
// Shared 48-bit unit: saturating add or greater-than compare on one adder.
module dojt_alu import dojt_pkg::*; (
  input  alu_op_t          op,
  input  logic [TimeW-1:0] a,
  input  logic [TimeW-1:0] b,
  output alu_res_t         res
);

  logic [TimeW-1:0] a_op;
  logic [TimeW:0]   total;

  // Compare computes b - a; a carry out means b >= a.
  always_comb begin
    a_op  = (op == ALU_ADD) ? a : ~a;
    total = {1'b0, b} + {1'b0, a_op} + {{TimeW{1'b0}}, (op == ALU_CMP)};
    res.sum = total[TimeW] ? {TimeW{1'b1}} : total[TimeW-1:0];
    res.gt  = ~total[TimeW];
  end

endmodule

[src/dojt_checker.sv]
// Port-level checks for the deadline job timer, bound to its top level.
`include "deadline_ordered_job_timer_defines.svh"

module dojt_checker import dojt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic [SDataW-1:0]  s_tdata,
  input logic [CmdW-1:0]    s_tuser,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [MDataW-1:0]  m_tdata,
  input logic [StatusW-1:0] m_tuser,
  input logic               m_tlast
);

  // A real command keeps the block busy for at least the next cycle
  `DOJT_ASSERT_NXT(a_busy_after_cmd, s_tvalid && s_tready && (s_tuser == CMD_RESERVE || s_tuser == CMD_DISTRIBUTE || s_tuser == CMD_CLEAR), !s_tready)

  // A stalled result holds
  `DOJT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // Only released jobs can be followed by more results of the same item
  `DOJT_ASSERT_IMP(a_single_last, m_tvalid && m_tuser != ST_DUE, m_tlast)

  // Full, none-due and cleared results carry zero fields
  `DOJT_ASSERT_IMP(a_zero_fields, m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_NONE || m_tuser == ST_CLEARED), m_tdata == '0)

endmodule

bind deadline_ordered_job_timer dojt_checker u_dojt_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the deadline-ordered job timer queue.
module tb_top;
  import dojt_pkg::*;

  localparam int Capacity    = 64;
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 300;
  localparam int HoldCycles  = 400;
  localparam logic [CmdW-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [TimeW-1:0] TimeMax    = {TimeW{1'b1}};

  // One request to the timer, as carried on the slave side.
  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [TimeW-1:0]  now;
    logic [DelayW-1:0] delay;
    logic [IdW-1:0]    owner;
    logic [IdW-1:0]    job;
  } job_cmd_t;

  // One result beat, as carried on the master side.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     owner;
    logic [IdW-1:0]     job;
    logic [TimeW-1:0]   due;
    logic               last;
  } timer_beat_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [SDataW-1:0]  s_tdata  = '0;
  logic [CmdW-1:0]    s_tuser  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [MDataW-1:0]  m_tdata;
  logic [StatusW-1:0] m_tuser;
  logic               m_tlast;

  job_cmd_t    job_cmds[$];       // requests not yet offered
  timer_beat_t timer_results[$];  // beats the timer still owes us
  job_cmd_t    next_cmd;

  // Shadow copy of the sorted job list.
  logic [TimeW-1:0] shadow_due   [Capacity];
  logic [IdW-1:0]   shadow_owner [Capacity];
  logic [IdW-1:0]   shadow_job   [Capacity];
  int               shadow_count = 0;

  int total_items   = 0;
  int items_taken   = 0;
  int mismatch_count = 0;
  int cycle_count   = 0;
  int stall_left    = 0;
  int holds_done    = 0;
  bit in_taken      = 1'b0;

  deadline_ordered_job_timer #(.CAPACITY(Capacity)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the shadow list by one accepted request and queue the beats it owes.
  task automatic apply_timer_cmd(input job_cmd_t c);
    timer_beat_t      beat;
    logic [TimeW:0]   sum;
    logic [TimeW-1:0] due;
    int               pos;
    int               n;
    int               k;
    beat      = '0;
    beat.last = 1'b1;
    case (c.cmd)
      CMD_RESERVE: begin
        if (shadow_count >= Capacity) begin
          beat.status = ST_FULL;
        end else begin
          // saturate the due time at the top of the 48-bit range
          sum = {1'b0, c.now} + {{(TimeW - DelayW + 1){1'b0}}, c.delay};
          due = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
          // slide later entries up; equal due times keep arrival order
          pos = shadow_count;
          while (pos > 0 && shadow_due[pos-1] > due) begin
            shadow_due[pos]   = shadow_due[pos-1];
            shadow_owner[pos] = shadow_owner[pos-1];
            shadow_job[pos]   = shadow_job[pos-1];
            pos--;
          end
          shadow_due[pos]   = due;
          shadow_owner[pos] = c.owner;
          shadow_job[pos]   = c.job;
          shadow_count++;
          beat.status = ST_ACCEPTED;
          beat.owner  = c.owner;
          beat.job    = c.job;
          beat.due    = due;
        end
        timer_results.insert(timer_results.size(), beat);
      end
      CMD_DISTRIBUTE: begin
        n = 0;
        while (n < shadow_count && n < MaxOut && shadow_due[n] <= c.now) n++;
        if (n == 0) begin
          beat.status = ST_NONE;
          timer_results.insert(timer_results.size(), beat);
        end else begin
          for (k = 0; k < n; k++) begin
            beat.status = ST_DUE;
            beat.owner  = shadow_owner[k];
            beat.job    = shadow_job[k];
            beat.due    = shadow_due[k];
            beat.last   = (k == n - 1);
            timer_results.insert(timer_results.size(), beat);
          end
          // drop the released head
          for (k = 0; k < shadow_count - n; k++) begin
            shadow_due[k]   = shadow_due[k+n];
            shadow_owner[k] = shadow_owner[k+n];
            shadow_job[k]   = shadow_job[k+n];
          end
          shadow_count -= n;
        end
      end
      CMD_CLEAR: begin
        shadow_count = 0;
        beat.status  = ST_CLEARED;
        timer_results.insert(timer_results.size(), beat);
      end
      default: ;  // unused code: no beat, no state change
    endcase
  endtask

  task automatic report_mismatch(input string why, input timer_beat_t want,
                                 input timer_beat_t seen);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"%0t %s: expected st=%0d own=%h job=%h due=%h last=%b,",
                " got st=%0d own=%h job=%h due=%h last=%b"},
               $time, why, want.status, want.owner, want.job, want.due, want.last,
               seen.status, seen.owner, seen.job, seen.due, seen.last);
  endtask

  function automatic logic [TimeW-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TimeW-1:0];
  endfunction

  function automatic logic [IdW-1:0] rand_id();
    return IdW'($urandom_range(65535));
  endfunction

  // Mostly short delays so jobs come due soon; some full-range, some zero.
  function automatic logic [DelayW-1:0] pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 70) return DelayW'($urandom_range(500));
    if (r < 85) return $urandom;
    return '0;
  endfunction

  task automatic push_cmd(input logic [CmdW-1:0] cmd, input logic [TimeW-1:0] now,
                          input logic [DelayW-1:0] delay, input logic [IdW-1:0] owner,
                          input logic [IdW-1:0] job);
    job_cmd_t c;
    c.cmd   = cmd;
    c.now   = now;
    c.delay = delay;
    c.owner = owner;
    c.job   = job;
    job_cmds.insert(job_cmds.size(), c);
  endtask

  // Idle odds per phase: sender 37 / receiver 66, then swapped, then none.
  function automatic int idle_pct(input bit sink_side);
    int phase;
    phase = (total_items == 0) ? 2 : (items_taken * 3) / total_items;
    if (phase == 0) return sink_side ? 66 : 37;
    if (phase == 1) return sink_side ? 37 : 66;
    return 0;
  endfunction

  // Sender: change at the falling edge, hold a beat until it is taken.
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || in_taken)) begin
      if (job_cmds.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
        next_cmd = job_cmds.pop_front();
        s_tdata  <= {next_cmd.job, next_cmd.owner, next_cmd.delay, next_cmd.now};
        s_tuser  <= next_cmd.cmd;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, forced low for the whole of a hold-off.
  always @(negedge clk) begin
    if (!rst)
      m_tready <= (stall_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
  end

  // Hold-off: starve the result side long enough that the timer backs up.
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (holds_done < 2 && items_taken >= 40 + 120 * holds_done) begin
      stall_left <= HoldCycles;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor: predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    job_cmd_t    taken;
    timer_beat_t seen;
    timer_beat_t want;
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      taken.cmd   = s_tuser;
      taken.now   = s_tdata[47:0];
      taken.delay = s_tdata[79:48];
      taken.owner = s_tdata[95:80];
      taken.job   = s_tdata[111:96];
      apply_timer_cmd(taken);
      items_taken <= items_taken + 1;
    end
    if (!rst && m_tvalid && m_tready) begin
      seen.status = m_tuser;
      seen.owner  = m_tdata[15:0];
      seen.job    = m_tdata[31:16];
      seen.due    = m_tdata[79:32];
      seen.last   = m_tlast;
      if (timer_results.size() == 0) begin
        report_mismatch("unexpected beat", '0, seen);
      end else begin
        want = timer_results.pop_front();
        if (want.status !== seen.status || want.owner !== seen.owner ||
            want.job !== seen.job || want.due !== seen.due || want.last !== seen.last)
          report_mismatch("beat mismatch", want, seen);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [TimeW-1:0]  clock_now;
    logic [DelayW-1:0] shared_delay;
    int                random_items;
    int                burst;
    int                pick;
    bit                fill_done;

    // Directed: empty queue, field extremes, saturation, ties, unused code.
    push_cmd(CMD_CLEAR, TimeMax, '1, '1, '1);
    push_cmd(CMD_DISTRIBUTE, '0, '0, '0, '0);                  // nothing stored yet
    push_cmd(CMD_RESERVE, '0, '0, '0, '0);                     // due at zero
    push_cmd(CMD_RESERVE, TimeMax, '1, '1, '1);                // sum overflows
    push_cmd(CMD_RESERVE, TimeMax - 48'd5, 32'd5, 16'h00a5, 16'h5a00); // lands on max
    push_cmd(CMD_RESERVE, 48'd1000, 32'd500, 16'd1, 16'd1);
    push_cmd(CMD_RESERVE, 48'd1200, 32'd300, 16'd2, 16'd2);    // tie, goes behind
    push_cmd(CMD_RESERVE, 48'd1499, 32'd1, 16'd3, 16'd3);      // tie again
    push_cmd(CMD_RESERVE, 48'd100, 32'd100, 16'd4, 16'd4);     // earlier, goes ahead
    push_cmd(CMD_UNUSED, TimeMax, '1, '1, '1);
    push_cmd(CMD_DISTRIBUTE, 48'd199, $urandom, rand_id(), rand_id());
    push_cmd(CMD_DISTRIBUTE, 48'd1500, '1, '1, '1);
    push_cmd(CMD_DISTRIBUTE, 48'd1499, '0, '0, '0);            // only far ones left
    push_cmd(CMD_DISTRIBUTE, TimeMax, '0, '0, '0);
    push_cmd(CMD_RESERVE, 48'd50, 32'd10, rand_id(), rand_id());
    push_cmd(CMD_RESERVE, 48'd50, 32'd20, rand_id(), rand_id());
    push_cmd(CMD_RESERVE, 48'd50, 32'd0, rand_id(), rand_id());
    push_cmd(CMD_CLEAR, '0, '0, '0, '0);
    push_cmd(CMD_DISTRIBUTE, TimeMax, '0, '0, '0);             // cleared, none due

    // Random: mostly reserve bursts closed by a distribute a little later.
    clock_now    = rand_time();
    random_items = 0;
    fill_done    = 1'b0;
    while (random_items < 200) begin
      if (!fill_done && random_items >= 80) begin
        // fill past capacity, then release all of it in one go
        push_cmd(CMD_CLEAR, rand_time(), $urandom, rand_id(), rand_id());
        repeat (Capacity + 2)
          push_cmd(CMD_RESERVE, clock_now, DelayW'($urandom_range(2000)), rand_id(),
                   rand_id());
        push_cmd(CMD_DISTRIBUTE, TimeMax, $urandom, rand_id(), rand_id());
        random_items += Capacity + 4;
        fill_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          clock_now = clock_now + $urandom_range(40);
          push_cmd(CMD_RESERVE, clock_now, pick_delay(), rand_id(), rand_id());
        end
        clock_now = clock_now + $urandom_range(300);
        push_cmd(CMD_DISTRIBUTE, clock_now, $urandom, rand_id(), rand_id());
        random_items += burst + 1;
      end else if (pick < 65) begin
        // same due time several times over
        burst        = $urandom_range(2, 4);
        shared_delay = pick_delay();
        repeat (burst) push_cmd(CMD_RESERVE, clock_now, shared_delay, rand_id(), rand_id());
        random_items += burst;
      end else if (pick < 75) begin
        push_cmd(CMD_DISTRIBUTE, $urandom_range(1) ? rand_time() : TimeMax, $urandom,
                 rand_id(), rand_id());
        random_items++;
      end else if (pick < 82) begin
        push_cmd(CMD_CLEAR, rand_time(), $urandom, rand_id(), rand_id());
        random_items++;
      end else if (pick < 88) begin
        push_cmd(CMD_UNUSED, rand_time(), $urandom, rand_id(), rand_id());
      end else if (pick < 94) begin
        // jump the clock anywhere in the range
        clock_now = rand_time();
        push_cmd(CMD_RESERVE, clock_now, pick_delay(), rand_id(), rand_id());
        random_items++;
      end else begin
        push_cmd(CMD_DISTRIBUTE, clock_now, $urandom, rand_id(), rand_id());
        random_items++;
      end
    end
    total_items = job_cmds.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every request to go in and every owed beat to come out.
    while (items_taken < total_items || timer_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && timer_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
